/* rtl/tgadec_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tgadec_pkg;

   // stream widths
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 112;

   // largest skip count before the id field and colour map are consumed
   localparam logic [18:0] SKIP_MAX = 19'h7FFFF;

   // parse phases
   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_SKIP   = 3'd1,
      PH_PACKET = 3'd2,
      PH_PIXEL  = 3'd3,
      PH_IDLE   = 3'd4
   } parse_phase_type;

   // one result item
   typedef struct packed {
      logic        result_kind;
      logic [7:0]  chan0;
      logic [7:0]  chan1;
      logic [7:0]  chan2;
      logic [7:0]  chan3;
      logic [2:0]  bytes_per_pixel;
      logic [31:0] first_index;
      logic [7:0]  run_length;
      logic        rows_bottom_up;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        image_done;
   } run_result_type;

   // result kinds
   localparam logic KIND_PIXEL_RUN = 1'b0;
   localparam logic KIND_REJECT    = 1'b1;

   // bytes per pixel at 32 bits per pixel
   localparam logic [2:0] BPP_ALPHA = 3'd4;

endpackage

`default_nettype wire

/* rtl/tga_rle_image_decoder_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// truecolor tga decoder, one file byte per request
// req channel: tdata is the file byte, tuser[0] marks the first byte of a new
//   file and clears all parsing state before that byte is taken as header byte 0
// rsp channel: one pixel run (tuser[0] = 0) or one header rejection (tuser[0] = 1,
//   tdata all zero); tlast is high on the run that completes the image
// types 2 and 10 at 16/24/32 bits per pixel are decoded; the id field and colour
//   map are skipped; 32 bpp runs come out premultiplied by alpha
// throughput: one request per clock while req_tready is high, with or without a result
// result path: a result reaches rsp through the parser register, then the
//   premultiply register, after the request that completes it is accepted
// stall: the two result registers fill while rsp_tready is low; req_tready
//   drops only once both hold a result, requests without a result are then
//   held too
// reset: synchronous, clears the parser to header byte 0 and empties both
//   result registers
// row mirroring is left to the frame writer, which gets the row order and the
// dimensions with every run

module tga_rle_image_decoder_unit
   import tgadec_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // [7:0] data_byte
   input  wire logic [0:0]             req_tuser,  // [0] file_start

   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [7:0] chan0, [15:8] chan1, [23:16] chan2, [31:24] chan3,
   // [34:32] bytes_per_pixel, [66:35] first_index, [74:67] run_length,
   // [75] rows_bottom_up, [91:76] image_width, [107:92] image_height, [111:108] zero
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   output logic [0:0]                  rsp_tuser,  // [0] result_kind
   output logic                        rsp_tlast   // image_done
);

   // parser to premultiply stage
   logic            s1_valid;
   logic            s1_take_ready;
   run_result_type  s1_res;

   // final result register
   run_result_type  out_res;

   tgadec_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .data_byte (req_tdata[7:0]),
      .file_start(req_tuser[0]),
      .res_valid (s1_valid),
      .res       (s1_res),
      .res_take  (s1_take_ready)
   );

   // alpha premultiply sits in front of the output register
   tgadec_premul u_premul (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s1_valid),
      .in_ready (s1_take_ready),
      .in_res   (s1_res),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_res  (out_res)
   );

   // pack the result fields, highest first
   assign rsp_tdata = {4'd0,
                       out_res.image_height,
                       out_res.image_width,
                       out_res.rows_bottom_up,
                       out_res.run_length,
                       out_res.first_index,
                       out_res.bytes_per_pixel,
                       out_res.chan3,
                       out_res.chan2,
                       out_res.chan1,
                       out_res.chan0};
   assign rsp_tuser = out_res.result_kind;
   assign rsp_tlast = out_res.image_done;

endmodule

`default_nettype wire

/* rtl/tgadec_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

module tgadec_parser
   import tgadec_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire logic [7:0]     data_byte,
   input  wire logic           file_start,
   output logic                res_valid,
   output run_result_type      res,
   input  wire logic           res_take
);

   // header byte offsets
   localparam logic [4:0] HDR_ID_LEN     = 5'd0;
   localparam logic [4:0] HDR_MAP_TYPE   = 5'd1;
   localparam logic [4:0] HDR_IMG_TYPE   = 5'd2;
   localparam logic [4:0] HDR_MAP_LEN_LO = 5'd5;
   localparam logic [4:0] HDR_MAP_LEN_HI = 5'd6;
   localparam logic [4:0] HDR_MAP_BITS   = 5'd7;
   localparam logic [4:0] HDR_WIDTH_LO   = 5'd12;
   localparam logic [4:0] HDR_WIDTH_HI   = 5'd13;
   localparam logic [4:0] HDR_HEIGHT_LO  = 5'd14;
   localparam logic [4:0] HDR_HEIGHT_HI  = 5'd15;
   localparam logic [4:0] HDR_PIX_BITS   = 5'd16;
   localparam logic [4:0] HDR_DESC       = 5'd17;

   localparam logic [7:0] TYPE_RAW = 8'd2;
   localparam logic [7:0] TYPE_RLE = 8'd10;
   localparam logic [7:0] MAP_NONE = 8'd0;
   localparam logic [7:0] MAP_USED = 8'd1;
   localparam logic [7:0] BITS_16  = 8'd16;
   localparam logic [7:0] BITS_24  = 8'd24;
   localparam logic [7:0] BITS_32  = 8'd32;

   parse_phase_type phase_ff, phase_in, phase_cur, data_phase;
   logic [4:0]  hpos_ff, hpos_in, hpos_cur;
   logic [7:0]  id_len_ff, id_len_in;
   logic [7:0]  map_type_ff, map_type_in;
   logic [7:0]  img_type_ff, img_type_in;
   logic [15:0] map_len_ff, map_len_in;
   logic [7:0]  map_bits_ff, map_bits_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [7:0]  pix_bits_ff, pix_bits_in;
   logic        desc_top_ff, desc_top_in;
   logic [18:0] skip_left_ff, skip_left_in;
   logic [7:0]  pkt_left_ff, pkt_left_in;
   logic        pkt_run_ff, pkt_run_in;
   logic [1:0]  byte_pos_ff, byte_pos_in;
   logic [23:0] asm_ff, asm_in;
   logic [31:0] pixels_done_ff, pixels_done_in;

   // values derived from settled header fields
   logic [31:0] total_ff;
   logic [18:0] skip_calc_ff, skip_calc_in;
   logic [5:0]  entry_bytes;
   logic [21:0] map_bytes;
   logic [22:0] skip_sum;

   logic            s1_valid_ff, s1_valid_in;
   run_result_type  s1_ff;

   logic            accept, start;
   logic            hdr_last, hdr_ok, type_rle;
   logic [2:0]      bpp;
   logic            pix_emit;
   logic [31:0]     remaining;
   logic [7:0]      run_len;
   logic            run_done;
   logic            new_valid;
   run_result_type  new_res;

   assign req_ready = !s1_valid_ff || res_take;
   assign accept    = req_valid && req_ready;
   assign start     = accept && file_start;

   assign phase_cur = start ? PH_HEADER : phase_ff;
   assign hpos_cur  = start ? 5'd0 : hpos_ff;

   assign hdr_last = (phase_cur == PH_HEADER) && (hpos_cur == HDR_DESC);
   assign hdr_ok   = ((img_type_ff == TYPE_RAW) || (img_type_ff == TYPE_RLE))
                   && ((pix_bits_ff == BITS_16) || (pix_bits_ff == BITS_24)
                       || (pix_bits_ff == BITS_32))
                   && ((map_type_ff == MAP_NONE) || (map_type_ff == MAP_USED));
   assign type_rle = (img_type_ff == TYPE_RLE);

   assign data_phase = ((width_ff == 16'd0) || (height_ff == 16'd0)) ? PH_IDLE :
                       (img_type_ff == TYPE_RAW) ? PH_PIXEL : PH_PACKET;

   assign bpp      = pix_bits_ff[5:3];
   assign pix_emit = (phase_cur == PH_PIXEL) && (({1'b0, byte_pos_ff} + 3'd1) == bpp);

   assign remaining = total_ff - pixels_done_ff;
   assign run_len   = !(type_rle && pkt_run_ff) ? 8'd1 :
                      ({24'd0, pkt_left_ff} < remaining) ? pkt_left_ff : remaining[7:0];
   assign run_done  = ({24'd0, run_len} == remaining);

   // colour map and id skip length, saturated
   assign entry_bytes  = 6'(({1'b0, map_bits_ff} + 9'd7) >> 3);
   assign map_bytes    = map_len_ff * entry_bytes;
   assign skip_sum     = (map_type_ff == MAP_USED) ? ({1'b0, map_bytes} + {15'd0, id_len_ff})
                                                   : {15'd0, id_len_ff};
   assign skip_calc_in = (skip_sum > {4'd0, SKIP_MAX}) ? SKIP_MAX : skip_sum[18:0];

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         phase_in = phase_cur;
         case (phase_cur)
            PH_HEADER: begin
               if (hdr_last) begin
                  if (!hdr_ok)
                     phase_in = PH_IDLE;
                  else if (skip_calc_ff == 19'd0)
                     phase_in = data_phase;
                  else
                     phase_in = PH_SKIP;
               end
            end
            PH_SKIP: begin
               if (skip_left_ff == 19'd1)
                  phase_in = data_phase;
            end
            PH_PACKET: begin
               phase_in = PH_PIXEL;
            end
            PH_PIXEL: begin
               if (pix_emit) begin
                  if (run_done)
                     phase_in = PH_IDLE;
                  else if (type_rle && (pkt_run_ff || (pkt_left_ff == 8'd1)))
                     phase_in = PH_PACKET;
               end
            end
            PH_IDLE: begin
               phase_in = PH_IDLE;
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase
      end
   end

   // datapath and result
   always_comb begin
      hpos_in        = hpos_ff;
      id_len_in      = id_len_ff;
      map_type_in    = map_type_ff;
      img_type_in    = img_type_ff;
      map_len_in     = map_len_ff;
      map_bits_in    = map_bits_ff;
      width_in       = width_ff;
      height_in      = height_ff;
      pix_bits_in    = pix_bits_ff;
      desc_top_in    = desc_top_ff;
      skip_left_in   = skip_left_ff;
      pkt_left_in    = pkt_left_ff;
      pkt_run_in     = pkt_run_ff;
      byte_pos_in    = byte_pos_ff;
      asm_in         = asm_ff;
      pixels_done_in = pixels_done_ff;
      new_valid      = 1'b0;
      new_res        = '0;

      if (start) begin
         id_len_in      = '0;
         map_type_in    = '0;
         img_type_in    = '0;
         map_len_in     = '0;
         map_bits_in    = '0;
         width_in       = '0;
         height_in      = '0;
         pix_bits_in    = '0;
         desc_top_in    = 1'b0;
         skip_left_in   = '0;
         pkt_left_in    = '0;
         pkt_run_in     = 1'b0;
         byte_pos_in    = '0;
         asm_in         = '0;
         pixels_done_in = '0;
      end

      if (accept) begin
         case (phase_cur)
            PH_HEADER: begin
               hpos_in = hpos_cur + 5'd1;
               case (hpos_cur)
                  HDR_ID_LEN:     id_len_in   = data_byte;
                  HDR_MAP_TYPE:   map_type_in = data_byte;
                  HDR_IMG_TYPE:   img_type_in = data_byte;
                  HDR_MAP_LEN_LO: map_len_in  = {map_len_ff[15:8], data_byte};
                  HDR_MAP_LEN_HI: map_len_in  = {data_byte, map_len_ff[7:0]};
                  HDR_MAP_BITS:   map_bits_in = data_byte;
                  HDR_WIDTH_LO:   width_in    = {width_ff[15:8], data_byte};
                  HDR_WIDTH_HI:   width_in    = {data_byte, width_ff[7:0]};
                  HDR_HEIGHT_LO:  height_in   = {height_ff[15:8], data_byte};
                  HDR_HEIGHT_HI:  height_in   = {data_byte, height_ff[7:0]};
                  HDR_PIX_BITS:   pix_bits_in = data_byte;
                  HDR_DESC:       desc_top_in = data_byte[5];
                  default: begin
                  end
               endcase
               if (hdr_last) begin
                  if (!hdr_ok) begin
                     new_valid           = 1'b1;
                     new_res.result_kind = KIND_REJECT;
                  end else begin
                     skip_left_in = skip_calc_ff;
                     byte_pos_in  = '0;
                     asm_in       = '0;
                  end
               end
            end
            PH_SKIP: begin
               skip_left_in = skip_left_ff - 19'd1;
               if (skip_left_ff == 19'd1) begin
                  byte_pos_in = '0;
                  asm_in      = '0;
               end
            end
            PH_PACKET: begin
               pkt_left_in = {1'b0, data_byte[6:0]} + 8'd1;
               pkt_run_in  = data_byte[7];
               byte_pos_in = '0;
               asm_in      = '0;
            end
            PH_PIXEL: begin
               if (pix_emit) begin
                  new_valid                = 1'b1;
                  new_res.result_kind      = KIND_PIXEL_RUN;
                  new_res.chan0            = asm_ff[7:0];
                  new_res.chan1            = (byte_pos_ff == 2'd1) ? data_byte : asm_ff[15:8];
                  new_res.chan2            = (bpp < 3'd3) ? 8'd0 :
                                             (byte_pos_ff == 2'd2) ? data_byte : asm_ff[23:16];
                  new_res.chan3            = (bpp == BPP_ALPHA) ? data_byte : 8'd0;
                  new_res.bytes_per_pixel  = bpp;
                  new_res.first_index      = pixels_done_ff;
                  new_res.run_length       = run_len;
                  new_res.rows_bottom_up   = !desc_top_ff;
                  new_res.image_width      = width_ff;
                  new_res.image_height     = height_ff;
                  new_res.image_done       = run_done;
                  byte_pos_in              = '0;
                  asm_in                   = '0;
                  pixels_done_in           = pixels_done_ff + {24'd0, run_len};
                  if (!run_done && type_rle && !pkt_run_ff)
                     pkt_left_in = pkt_left_ff - 8'd1;
               end else begin
                  byte_pos_in = byte_pos_ff + 2'd1;
                  case (byte_pos_ff)
                     2'd0:    asm_in[7:0]   = data_byte;
                     2'd1:    asm_in[15:8]  = data_byte;
                     2'd2:    asm_in[23:16] = data_byte;
                     default: asm_in        = asm_ff;
                  endcase
               end
            end
            PH_IDLE: begin
            end
            default: begin
            end
         endcase
      end
   end

   assign s1_valid_in = (accept && new_valid) ? 1'b1 :
                        res_take ? 1'b0 : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEADER;
         hpos_ff        <= '0;
         id_len_ff      <= '0;
         map_type_ff    <= '0;
         img_type_ff    <= '0;
         map_len_ff     <= '0;
         map_bits_ff    <= '0;
         width_ff       <= '0;
         height_ff      <= '0;
         pix_bits_ff    <= '0;
         desc_top_ff    <= 1'b0;
         skip_left_ff   <= '0;
         pkt_left_ff    <= '0;
         pkt_run_ff     <= 1'b0;
         byte_pos_ff    <= '0;
         asm_ff         <= '0;
         pixels_done_ff <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         hpos_ff        <= hpos_in;
         id_len_ff      <= id_len_in;
         map_type_ff    <= map_type_in;
         img_type_ff    <= img_type_in;
         map_len_ff     <= map_len_in;
         map_bits_ff    <= map_bits_in;
         width_ff       <= width_in;
         height_ff      <= height_in;
         pix_bits_ff    <= pix_bits_in;
         desc_top_ff    <= desc_top_in;
         skip_left_ff   <= skip_left_in;
         pkt_left_ff    <= pkt_left_in;
         pkt_run_ff     <= pkt_run_in;
         byte_pos_ff    <= byte_pos_in;
         asm_ff         <= asm_in;
         pixels_done_ff <= pixels_done_in;
         s1_valid_ff    <= s1_valid_in;
      end
   end

   // header products settle many bytes before they are used
   always_ff @(posedge clock) begin
      total_ff     <= width_ff * height_ff;
      skip_calc_ff <= skip_calc_in;
      if (accept && new_valid)
         s1_ff <= new_res;
   end

   assign res_valid = s1_valid_ff;
   assign res       = s1_ff;

`ifndef SYNTH
   a_run_len_range: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (s1_ff.result_kind == KIND_PIXEL_RUN))
         |-> ((s1_ff.run_length != 8'd0) && (s1_ff.run_length <= 8'd128)))
      else $error("pixel run length out of range");

   a_bpp_range: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (s1_ff.result_kind == KIND_PIXEL_RUN))
         |-> ((s1_ff.bytes_per_pixel == 3'd2) || (s1_ff.bytes_per_pixel == 3'd3)
              || (s1_ff.bytes_per_pixel == 3'd4)))
      else $error("pixel run with unsupported pixel size");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (s1_ff.result_kind == KIND_REJECT))
         |-> ((s1_ff.run_length == 8'd0) && (s1_ff.first_index == 32'd0)
              && (s1_ff.image_width == 16'd0) && !s1_ff.image_done))
      else $error("rejection result carries payload");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !res_take) |=> (s1_valid_ff && $stable(s1_ff)))
      else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

/* rtl/tgadec_premul.sv */
`timescale 1ns / 1ps
`default_nettype none

module tgadec_premul
   import tgadec_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire run_result_type in_res,
   output logic                out_valid,
   input  wire logic           out_ready,
   output run_result_type      out_res
);

   logic            out_valid_ff, out_valid_in;
   run_result_type  out_ff, out_in;
   logic [15:0]     prod0, prod1, prod2;

   // floor(x / 255) for x up to 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return t[15:8];
   endfunction

   assign in_ready = !out_valid_ff || out_ready;

   assign prod0 = in_res.chan0 * in_res.chan3;
   assign prod1 = in_res.chan1 * in_res.chan3;
   assign prod2 = in_res.chan2 * in_res.chan3;

   always_comb begin
      out_in = in_res;
      if ((in_res.result_kind == KIND_PIXEL_RUN) && (in_res.bytes_per_pixel == BPP_ALPHA)) begin
         out_in.chan0 = div255(prod0);
         out_in.chan1 = div255(prod1);
         out_in.chan2 = div255(prod2);
      end
   end

   assign out_valid_in = in_ready ? in_valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready)
         out_ff <= out_in;
   end

   assign out_valid = out_valid_ff;
   assign out_res   = out_ff;

endmodule

`default_nettype wire

/* dv/tgadec_tb_pkg.sv */
`timescale 1ns / 1ps

package tgadec_tb_pkg;

   // tga header layout, byte offsets
   localparam int HDR_BYTES      = 18;
   localparam int HDR_ID_LEN     = 0;
   localparam int HDR_MAP_KIND   = 1;
   localparam int HDR_IMG_TYPE   = 2;
   localparam int HDR_MAP_LEN_LO = 5;
   localparam int HDR_MAP_LEN_HI = 6;
   localparam int HDR_MAP_BITS   = 7;
   localparam int HDR_WIDTH_LO   = 12;
   localparam int HDR_WIDTH_HI   = 13;
   localparam int HDR_HEIGHT_LO  = 14;
   localparam int HDR_HEIGHT_HI  = 15;
   localparam int HDR_PIX_BITS   = 16;
   localparam int HDR_DESC       = 17;

   // image types the decoder handles
   localparam logic [7:0] IMG_TYPE_RAW = 8'd2;
   localparam logic [7:0] IMG_TYPE_RLE = 8'd10;

   // colour map types
   localparam logic [7:0] MAP_NONE    = 8'd0;
   localparam logic [7:0] MAP_PRESENT = 8'd1;

   // rle packet header
   localparam logic [7:0] PKT_RUN_FLAG   = 8'h80;
   localparam logic [7:0] PKT_COUNT_MASK = 8'h7F;

   // descriptor bit for top-down row order
   localparam logic [7:0] DESC_TOP_DOWN = 8'h20;

endpackage

/* dv/tga_run_checker.sv */
`timescale 1ns / 1ps

module tga_run_checker
   import tgadec_pkg::*;
   import tgadec_tb_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic [0:0]             req_tuser,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  wire logic [0:0]             rsp_tuser,
   input  wire logic                   rsp_tlast,
   output int                          mismatch_count,
   output int                          runs_pending
);

   localparam int MAX_REPORTED = 10;

   parse_phase_type phase;
   logic [4:0]  hdr_pos;
   logic [7:0]  id_len, map_kind, img_type, map_bits, pix_bits, desc;
   logic [15:0] map_len, img_w, img_h;
   logic [18:0] skip_left;
   logic [7:0]  pkt_left;
   logic        pkt_is_run;
   logic [1:0]  byte_pos;
   logic [31:0] assembly;
   logic [31:0] pixels_out;

   run_result_type expected_runs[$];
   int mismatches = 0;
   int runs_seen = 0;

   task automatic clear_parser();
      phase      = PH_HEADER;
      hdr_pos    = '0;
      id_len     = '0;
      map_kind   = '0;
      img_type   = '0;
      map_len    = '0;
      map_bits   = '0;
      img_w      = '0;
      img_h      = '0;
      pix_bits   = '0;
      desc       = '0;
      skip_left  = '0;
      pkt_left   = '0;
      pkt_is_run = 1'b0;
      byte_pos   = '0;
      assembly   = '0;
      pixels_out = '0;
   endtask

   function automatic logic [32:0] pixel_total();
      return 33'(img_w) * 33'(img_h);
   endfunction

   function automatic logic [7:0] premultiply(logic [7:0] c, logic [7:0] alpha);
      return 8'((16'(c) * 16'(alpha)) / 16'd255);
   endfunction

   task automatic start_pixels();
      byte_pos = '0;
      assembly = '0;
      if (pixel_total() == '0)
         phase = PH_IDLE;
      else if (img_type == IMG_TYPE_RAW)
         phase = PH_PIXEL;
      else
         phase = PH_PACKET;
   endtask

   // advance the decoder by one file byte, queue the run or rejection it yields
   task automatic take_byte(input logic [7:0] b, input logic first);
      logic [23:0]    skip;
      logic [2:0]     bpp;
      logic [7:0]     c0, c1, c2, c3, len;
      logic [32:0]    remaining;
      run_result_type run;
      if (first)
         clear_parser();
      case (phase)
         PH_HEADER: begin
            case (hdr_pos)
               HDR_ID_LEN:     id_len = b;
               HDR_MAP_KIND:   map_kind = b;
               HDR_IMG_TYPE:   img_type = b;
               HDR_MAP_LEN_LO: map_len[7:0] = b;
               HDR_MAP_LEN_HI: map_len[15:8] = b;
               HDR_MAP_BITS:   map_bits = b;
               HDR_WIDTH_LO:   img_w[7:0] = b;
               HDR_WIDTH_HI:   img_w[15:8] = b;
               HDR_HEIGHT_LO:  img_h[7:0] = b;
               HDR_HEIGHT_HI:  img_h[15:8] = b;
               HDR_PIX_BITS:   pix_bits = b;
               HDR_DESC:       desc = b;
               default: ;
            endcase
            hdr_pos = hdr_pos + 5'd1;
            if (hdr_pos == 5'(HDR_BYTES)) begin
               if (!((img_type == IMG_TYPE_RAW || img_type == IMG_TYPE_RLE)
                     && (pix_bits == 8'd16 || pix_bits == 8'd24 || pix_bits == 8'd32)
                     && (map_kind == MAP_NONE || map_kind == MAP_PRESENT))) begin
                  phase = PH_IDLE;
                  run = '0;
                  run.result_kind = KIND_REJECT;
                  expected_runs.push_back(run);
               end else begin
                  skip = 24'(id_len);
                  if (map_kind == MAP_PRESENT)
                     skip = skip + 24'(map_len) * ((24'(map_bits) + 24'd7) / 24'd8);
                  skip_left = (skip > 24'(SKIP_MAX)) ? SKIP_MAX : skip[18:0];
                  if (skip_left == '0)
                     start_pixels();
                  else
                     phase = PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            skip_left = skip_left - 19'd1;
            if (skip_left == '0)
               start_pixels();
         end
         PH_PACKET: begin
            pkt_left   = (b & PKT_COUNT_MASK) + 8'd1;
            pkt_is_run = ((b & PKT_RUN_FLAG) != 8'd0);
            byte_pos   = '0;
            assembly   = '0;
            phase      = PH_PIXEL;
         end
         PH_PIXEL: begin
            bpp = 3'(pix_bits / 8'd8);
            assembly = assembly | (32'(b) << {byte_pos, 3'b000});
            byte_pos = byte_pos + 2'd1;
            if (byte_pos != 2'd0 && {1'b0, byte_pos} < bpp)
               return;
            c0 = assembly[7:0];
            c1 = assembly[15:8];
            c2 = (bpp >= 3'd3) ? assembly[23:16] : 8'd0;
            c3 = (bpp == BPP_ALPHA) ? assembly[31:24] : 8'd0;
            if (bpp == BPP_ALPHA) begin
               c0 = premultiply(c0, c3);
               c1 = premultiply(c1, c3);
               c2 = premultiply(c2, c3);
            end
            byte_pos  = '0;
            assembly  = '0;
            remaining = pixel_total() - 33'(pixels_out);
            len = 8'd1;
            if (img_type == IMG_TYPE_RLE && pkt_is_run)
               len = (33'(pkt_left) < remaining) ? pkt_left : remaining[7:0];
            run.result_kind     = KIND_PIXEL_RUN;
            run.chan0           = c0;
            run.chan1           = c1;
            run.chan2           = c2;
            run.chan3           = c3;
            run.bytes_per_pixel = bpp;
            run.first_index     = pixels_out;
            run.run_length      = len;
            run.rows_bottom_up  = ((desc & DESC_TOP_DOWN) == 8'd0);
            run.image_width     = img_w;
            run.image_height    = img_h;
            run.image_done      = (33'(len) == remaining);
            expected_runs.push_back(run);
            pixels_out = pixels_out + 32'(len);
            if (run.image_done) begin
               phase = PH_IDLE;
            end else if (img_type == IMG_TYPE_RLE) begin
               if (pkt_is_run) begin
                  phase = PH_PACKET;
               end else begin
                  pkt_left = pkt_left - 8'd1;
                  if (pkt_left == 8'd0)
                     phase = PH_PACKET;
               end
            end
         end
         default: ;
      endcase
   endtask

   function automatic string run_text(run_result_type r);
      return $sformatf({"kind=%0d ch=%02h/%02h/%02h/%02h bpp=%0d first=%0d len=%0d",
                        " bottom_up=%0d w=%0d h=%0d done=%0d"},
                       r.result_kind, r.chan0, r.chan1, r.chan2, r.chan3,
                       r.bytes_per_pixel, r.first_index, r.run_length,
                       r.rows_bottom_up, r.image_width, r.image_height, r.image_done);
   endfunction

   task automatic check_run(input run_result_type seen);
      run_result_type want;
      string          diff;
      runs_seen++;
      if (expected_runs.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_REPORTED)
            $display("run %0d: nothing expected, got %s", runs_seen, run_text(seen));
         return;
      end
      want = expected_runs.pop_front();
      diff = "";
      if (seen.result_kind !== want.result_kind)         diff = {diff, " result_kind"};
      if (seen.chan0 !== want.chan0)                     diff = {diff, " chan0"};
      if (seen.chan1 !== want.chan1)                     diff = {diff, " chan1"};
      if (seen.chan2 !== want.chan2)                     diff = {diff, " chan2"};
      if (seen.chan3 !== want.chan3)                     diff = {diff, " chan3"};
      if (seen.bytes_per_pixel !== want.bytes_per_pixel) diff = {diff, " bytes_per_pixel"};
      if (seen.first_index !== want.first_index)         diff = {diff, " first_index"};
      if (seen.run_length !== want.run_length)           diff = {diff, " run_length"};
      if (seen.rows_bottom_up !== want.rows_bottom_up)   diff = {diff, " rows_bottom_up"};
      if (seen.image_width !== want.image_width)         diff = {diff, " image_width"};
      if (seen.image_height !== want.image_height)       diff = {diff, " image_height"};
      if (seen.image_done !== want.image_done)           diff = {diff, " image_done"};
      if (diff != "") begin
         mismatches++;
         if (mismatches <= MAX_REPORTED)
            $display("run %0d mismatch in%s\n   expected %s\n   actual   %s",
                     runs_seen, diff, run_text(want), run_text(seen));
      end
   endtask

   always @(posedge clock) begin
      run_result_type seen;
      if (reset) begin
         clear_parser();
         expected_runs.delete();
      end else begin
         if (req_tvalid && req_tready)
            take_byte(req_tdata, req_tuser[0]);
         if (rsp_tvalid && rsp_tready) begin
            seen.result_kind     = rsp_tuser[0];
            seen.chan0           = rsp_tdata[7:0];
            seen.chan1           = rsp_tdata[15:8];
            seen.chan2           = rsp_tdata[23:16];
            seen.chan3           = rsp_tdata[31:24];
            seen.bytes_per_pixel = rsp_tdata[34:32];
            seen.first_index     = rsp_tdata[66:35];
            seen.run_length      = rsp_tdata[74:67];
            seen.rows_bottom_up  = rsp_tdata[75];
            seen.image_width     = rsp_tdata[91:76];
            seen.image_height    = rsp_tdata[107:92];
            seen.image_done      = rsp_tlast;
            check_run(seen);
         end
      end
      runs_pending   <= expected_runs.size();
      mismatch_count <= mismatches;
   end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import tgadec_pkg::*;
   import tgadec_tb_pkg::*;

   localparam int HOLD_AFTER_RUNS = 30;   // results taken before the long hold-off
   localparam int HOLD_CYCLES     = 400;  // long enough to fill both result registers
   localparam int DRAIN_CYCLES    = 20;   // extra wait after every expected result is taken
   localparam int RANDOM_BYTES    = 300;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [0:0]             req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b1;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [0:0]             rsp_tuser;
   logic                   rsp_tlast;
   int                     mismatch_count;
   int                     runs_pending;

   int bytes_sent = 0;
   int req_quiet  = 0;

   tga_rle_image_decoder_unit dut (.*);

   tga_run_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the handshake hangs
   initial begin
      #30_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // idle count for one item: usually random, sometimes a stretch with no idling
   task automatic draw_gap(inout int quiet_left, output int gap);
      if (quiet_left > 0) begin
         quiet_left--;
         gap = 0;
      end else if ($urandom_range(0, 31) == 0) begin
         quiet_left = $urandom_range(8, 40);
         gap = 0;
      end else begin
         gap = $urandom_range(0, 11);
      end
   endtask

   // byte values weighted toward the extremes
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // one request; valid stays high into the next call when it has no gap
   task automatic send_byte(input logic [7:0] b, input logic first);
      int gap;
      draw_gap(req_quiet, gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tdata    <= b;
      req_tuser[0] <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_filler(input int n);
      for (int i = 0; i < n; i++)
         send_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   task automatic send_pixel(input int n);
      for (int i = 0; i < n; i++)
         send_byte(pick_byte(), 1'b0);
   endtask

   // 18-byte header, the fields the decoder ignores are random
   task automatic send_header(input logic first, input logic [7:0] id_len,
                              input logic [7:0] map_kind, input logic [7:0] img_type,
                              input logic [15:0] map_len, input logic [7:0] map_bits,
                              input logic [15:0] w, input logic [15:0] h,
                              input logic [7:0] pix_bits, input logic [7:0] desc);
      logic [7:0] hdr [HDR_BYTES];
      for (int i = 0; i < HDR_BYTES; i++)
         hdr[i] = 8'($urandom_range(0, 255));
      hdr[HDR_ID_LEN]     = id_len;
      hdr[HDR_MAP_KIND]   = map_kind;
      hdr[HDR_IMG_TYPE]   = img_type;
      hdr[HDR_MAP_LEN_LO] = map_len[7:0];
      hdr[HDR_MAP_LEN_HI] = map_len[15:8];
      hdr[HDR_MAP_BITS]   = map_bits;
      hdr[HDR_WIDTH_LO]   = w[7:0];
      hdr[HDR_WIDTH_HI]   = w[15:8];
      hdr[HDR_HEIGHT_LO]  = h[7:0];
      hdr[HDR_HEIGHT_HI]  = h[15:8];
      hdr[HDR_PIX_BITS]   = pix_bits;
      hdr[HDR_DESC]       = desc;
      for (int i = 0; i < HDR_BYTES; i++)
         send_byte(hdr[i], first && (i == 0));
   endtask

   // bytes of id field plus colour map
   function automatic int skip_bytes(logic [7:0] id_len, logic [7:0] map_kind,
                                     logic [15:0] map_len, logic [7:0] map_bits);
      return int'(id_len) +
             ((map_kind == MAP_PRESENT) ? int'(map_len) * ((int'(map_bits) + 7) / 8) : 0);
   endfunction

   // well-formed file with random content; pix_count below the total abandons it
   task automatic send_image(input logic [7:0] img_type, input logic [7:0] pix_bits,
                             input logic [15:0] w, input logic [15:0] h,
                             input int pix_count);
      logic [7:0]  id_len, map_kind, map_bits;
      logic [15:0] map_len;
      int          sent, n, is_run;
      id_len   = 8'($urandom_range(0, 3));
      map_kind = ($urandom_range(0, 1) == 0) ? MAP_NONE : MAP_PRESENT;
      map_len  = 16'($urandom_range(0, 3));
      map_bits = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(15, 32));
      send_header(1'b1, id_len, map_kind, img_type, map_len, map_bits, w, h, pix_bits,
                  pick_byte());
      send_filler(skip_bytes(id_len, map_kind, map_len, map_bits));
      sent = 0;
      while (sent < pix_count) begin
         if (img_type == IMG_TYPE_RLE) begin
            // packet count mostly short, sometimes up to 128 so runs get clipped
            n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 5);
            is_run = $urandom_range(0, 1);
            send_byte((is_run != 0 ? PKT_RUN_FLAG : 8'h00) | (8'(n) & PKT_COUNT_MASK), 1'b0);
            if (is_run != 0) begin
               send_pixel(pix_bits / 8);
               sent += n + 1;
            end else begin
               for (int i = 0; i <= n && sent < pix_count; i++) begin
                  send_pixel(pix_bits / 8);
                  sent++;
               end
            end
         end else begin
            send_pixel(pix_bits / 8);
            sent++;
         end
      end
   endtask

   // result side: random stall after each result, one long hold-off under load
   initial begin : rsp_side
      int  stall;
      int  quiet_left;
      int  taken;
      bit  held;
      stall = 0;
      quiet_left = 0;
      taken = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            taken++;
            if (!held && taken == HOLD_AFTER_RUNS) begin
               stall = HOLD_CYCLES;
               held = 1'b1;
            end else begin
               draw_gap(quiet_left, stall);
            end
         end else if (stall > 0) begin
            stall--;
         end
         rsp_tready <= (stall == 0);
      end
   end

   initial begin : stimulus
      int          choice, total, npix, is_rle;
      logic [7:0]  img_type, pix_bits, map_kind;
      logic [15:0] w, h;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // first file without a start marker, parsed from reset; 1x1 raw 24 bpp
      send_header(1'b0, 8'd0, MAP_NONE, IMG_TYPE_RAW, 16'd0, 8'd0, 16'd1, 16'd1, 8'd24,
                  DESC_TOP_DOWN);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b0);

      // rejections: bad image type, bad pixel size, bad colour map type
      send_header(1'b1, 8'd0, MAP_NONE, 8'd3, 16'd0, 8'd0, 16'd2, 16'd2, 8'd24, 8'h00);
      send_filler(2);
      send_header(1'b1, 8'd0, MAP_NONE, IMG_TYPE_RAW, 16'd0, 8'd0, 16'd2, 16'd2, 8'd8,
                  8'h00);
      send_header(1'b1, 8'd0, 8'd2, IMG_TYPE_RLE, 16'd0, 8'd0, 16'd2, 16'd2, 8'd32, 8'h00);

      // one 128-pixel run clipped to a 3-pixel image, trailing bytes ignored
      send_header(1'b1, 8'd2, MAP_NONE, IMG_TYPE_RLE, 16'd0, 8'd0, 16'd3, 16'd1, 8'd32,
                  DESC_TOP_DOWN);
      send_filler(skip_bytes(8'd2, MAP_NONE, 16'd0, 8'd0));
      send_byte(PKT_RUN_FLAG | PKT_COUNT_MASK, 1'b0);
      send_pixel(0);
      for (int i = 0; i < 4; i++)
         send_byte(8'hFF, 1'b0);
      send_filler(3);

      // rle 16 bpp 2x2 behind an id field and a colour map: raw packet, then a run
      send_header(1'b1, 8'd1, MAP_PRESENT, IMG_TYPE_RLE, 16'd2, 8'd15, 16'd2, 16'd2,
                  8'd16, 8'h00);
      send_filler(skip_bytes(8'd1, MAP_PRESENT, 16'd2, 8'd15));
      send_byte(8'h01, 1'b0);
      send_pixel(4);
      send_byte(PKT_RUN_FLAG | 8'h01, 1'b0);
      send_pixel(2);

      // empty image, every later byte ignored
      send_header(1'b1, 8'd0, MAP_NONE, IMG_TYPE_RAW, 16'd0, 8'd0, 16'd0, 16'd5, 8'd24,
                  8'h00);
      send_filler(3);

      // 32 bpp premultiply at zero alpha and at a middle alpha
      send_header(1'b1, 8'd0, MAP_NONE, IMG_TYPE_RAW, 16'd0, 8'd0, 16'd2, 16'd1, 8'd32,
                  8'h00);
      for (int i = 0; i < 3; i++)
         send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h40, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h7F, 1'b0);

      // largest dimensions, abandoned after two pixels by the next file
      send_header(1'b1, 8'd0, MAP_NONE, IMG_TYPE_RAW, 16'd0, 8'd0, 16'hFFFF, 16'hFFFF,
                  8'd24, 8'h00);
      send_pixel(6);

      // random files: mostly well-formed, some rejected headers and raw noise
      bytes_sent = 0;
      while (bytes_sent < RANDOM_BYTES) begin
         choice = $urandom_range(0, 19);
         if (choice < 14) begin
            is_rle   = $urandom_range(0, 1);
            img_type = (is_rle != 0) ? IMG_TYPE_RLE : IMG_TYPE_RAW;
            pix_bits = 8'(16 + 8 * $urandom_range(0, 2));
            if (choice == 0) begin
               w = 16'($urandom_range(0, 1) * $urandom_range(0, 4));
               h = (w == 16'd0) ? 16'($urandom_range(0, 4)) : 16'd0;
            end else if (choice == 1 && is_rle != 0) begin
               // one long row so 128-pixel runs fit and get clipped at the end
               w = 16'($urandom_range(129, 300));
               h = 16'd1;
            end else begin
               w = 16'($urandom_range(1, 6));
               h = 16'($urandom_range(1, 4));
            end
            total = int'(w) * int'(h);
            npix = (total > 0 && $urandom_range(0, 7) == 0) ? $urandom_range(0, total - 1)
                                                            : total;
            send_image(img_type, pix_bits, w, h, npix);
            send_filler($urandom_range(0, 2));
         end else if (choice < 17) begin
            img_type = ($urandom_range(0, 1) == 0) ? IMG_TYPE_RAW : IMG_TYPE_RLE;
            pix_bits = 8'(16 + 8 * $urandom_range(0, 2));
            map_kind = ($urandom_range(0, 1) == 0) ? MAP_NONE : MAP_PRESENT;
            case ($urandom_range(0, 2))
               0: do img_type = 8'($urandom_range(0, 255));
                  while (img_type == IMG_TYPE_RAW || img_type == IMG_TYPE_RLE);
               1: do pix_bits = 8'($urandom_range(0, 255));
                  while (pix_bits == 8'd16 || pix_bits == 8'd24 || pix_bits == 8'd32);
               default: map_kind = 8'($urandom_range(2, 255));
            endcase
            send_header(1'b1, pick_byte(), map_kind, img_type, 16'($urandom_range(0, 65535)),
                        pick_byte(), 16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)),
                        pix_bits, pick_byte());
            send_filler($urandom_range(0, 3));
         end else begin
            repeat ($urandom_range(1, 12))
               send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         end
      end

      // drain: let the checker see the last request, then wait for every result
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (runs_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
